[hw/rtl/qslerp_pkg.sv]
// Shared constants and the arctangent table of the quaternion slerp datapath.
`timescale 1ns / 1ps

package qslerp_pkg;

   // Fixed widths of the angle and weight datapath.
   localparam int C_W          = 30;  // cosine term, Q0.30
   localparam int RAD_W        = 61;  // radicand 2^60 - c^2
   localparam int ROOT_W       = 31;  // square root, up to 2^30
   localparam int CX_W         = 33;  // CORDIC x and y
   localparam int Z_W          = 20;  // CORDIC angle, Q16 radians
   localparam int T_W          = 17;  // blend weight, Q1.16
   localparam int REM_W        = 62;  // divider remainder

   // Pipeline depths of the iterative units.
   localparam int CORDIC_STEPS = 17;
   localparam int ISQ_STAGES   = 31;
   localparam int DIV_STAGES   = 32;

   localparam logic [T_W-1:0]  WEIGHT_ONE = 17'd65536;
   localparam logic [31:0]     GAIN_INV   = 32'd652032874;

   // Arctangent of 2^-i in Q16 radians.
   function automatic logic [16:0] atan_q16(input logic [4:0] idx);
      logic [16:0] v;
      case (idx)
         5'd0:    v = 17'd51472;
         5'd1:    v = 17'd30386;
         5'd2:    v = 17'd16055;
         5'd3:    v = 17'd8150;
         5'd4:    v = 17'd4091;
         5'd5:    v = 17'd2047;
         5'd6:    v = 17'd1024;
         5'd7:    v = 17'd512;
         5'd8:    v = 17'd256;
         5'd9:    v = 17'd128;
         5'd10:   v = 17'd64;
         5'd11:   v = 17'd32;
         5'd12:   v = 17'd16;
         5'd13:   v = 17'd8;
         5'd14:   v = 17'd4;
         5'd15:   v = 17'd2;
         5'd16:   v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/quaternion_slerp.sv]
// Top level of the fixed-point quaternion slerp pipeline.
//
// Usage: the req_ channel carries one item per handshake: start and target
// quaternion (signed Q1.14) and a blend weight (unsigned Q1.16, 65536 = 1.0,
// larger values count as 1.0). The rsp_ channel returns one item per request:
// the blended quaternion, saturated, with tuser set when the near-identical
// inputs were blended with linear weights. csr_ writes the closeness threshold
// of the linear fallback; write it only while no item is in flight.
// The pipeline has 107 register stages: six front stages for the dot product
// and radicand, 31 square-root stages, 17 vectoring CORDIC stages, two stages
// for the arc split, 17 rotation CORDIC stages, 32 divider stages and two
// output stages. The square root and the divider set the depth, one bit per
// stage. Throughput is one item per cycle while the output is not stalled.
// All stages advance together whenever the output register is empty or
// taken; when the receiver stalls the whole pipeline holds, req_tready falls
// and nothing is lost or repeated.
// Reset clears every valid bit and sets the threshold to one LSB.
`timescale 1ns / 1ps

module quaternion_slerp #(
   parameter int COMP_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w, weight, padding
   input  logic [((8*COMP_WIDTH+17+7)/8)*8-1:0]       req_tdata,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // out_x, out_y, out_z, out_w, padding
   output logic [((4*COMP_WIDTH+7)/8)*8-1:0]          rsp_tdata,
   // linear_case
   output logic                                       rsp_tuser,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   input  logic                                       csr_wen,
   input  logic [10:0]                                csr_wdata
);
   import qslerp_pkg::*;

   localparam int CW   = COMP_WIDTH;
   localparam int DW   = 2 * CW - FRAC_BITS + 2;
   localparam int PW0  = 32 + CW;
   localparam int PW1  = 33 + CW;
   localparam int SUMW = 34 + CW;

   // Stage positions along the pipeline.
   localparam int P_IN   = 0;
   localparam int P_MUL  = 1;
   localparam int P_DOT  = 2;
   localparam int P_SGN  = 3;
   localparam int P_SQ   = 4;
   localparam int P_RAD  = 5;
   localparam int P_ROOT = P_RAD + ISQ_STAGES;
   localparam int P_ANG  = P_ROOT + CORDIC_STEPS;
   localparam int P_TW   = P_ANG + 1;
   localparam int P_ARC  = P_TW + 1;
   localparam int P_SIN  = P_ARC + CORDIC_STEPS;
   localparam int P_QUO  = P_SIN + DIV_STAGES;
   localparam int P_PRD  = P_QUO + 1;
   localparam int P_OUT  = P_PRD + 1;

   localparam logic signed [DW+1:0]   ONE_DOT = (DW+2)'(1) <<< FRAC_BITS;
   localparam logic [60:0]            RAD_ONE = 61'(1) << 60;
   localparam logic [ROOT_W-1:0]      W_ONE   = ROOT_W'(1) << 30;
   localparam logic signed [SUMW-1:0] ROUND   = SUMW'(1) <<< 29;
   localparam logic signed [SUMW-1:0] MAXV    = (SUMW'(1) <<< (CW - 1)) - SUMW'(1);
   localparam logic signed [SUMW-1:0] MINV    = -MAXV - SUMW'(1);

   // Values that travel beside the arithmetic through every stage.
   typedef struct packed {
      logic signed [3:0][CW-1:0] a;
      logic signed [3:0][CW:0]   b;
      logic [T_W-1:0]            t;
      logic                      lin;
      logic [C_W-1:0]            c;
      logic [ROOT_W-1:0]         s;
   } side_type;

   logic                       en;
   logic                       valid_ff [P_OUT+1];
   side_type                   side_ff  [P_PRD+1];
   side_type                   side_in  [P_PRD+1];
   logic [10:0]                thr_ff;

   logic signed [2*CW-1:0]     prod_ff [4];
   logic signed [DW-1:0]       dot_ff;
   logic signed [DW:0]         dot_ext, dabs;
   logic signed [DW+1:0]       dot_gap;
   logic                       lin_in;
   logic [C_W-1:0]             c_in;
   logic [2*C_W-1:0]           cc_ff;
   logic [RAD_W-1:0]           rad_ff;
   logic [ROOT_W-1:0]          root;
   logic signed [Z_W-1:0]      angle;
   logic [T_W-1:0]             wpos;
   logic [T_W-1:0]             w_ff;
   logic [2*T_W-1:0]           tw_ff;
   logic signed [Z_W-1:0]      a1_ff, a0_ff;
   logic signed [CX_W-1:0]     sine1, sine0;
   logic [ROOT_W-1:0]          q1, q0;
   logic [ROOT_W-1:0]          s1_sel, s0_sel, s1_lin;
   logic signed [PW0-1:0]      fin0_ff [4];
   logic signed [PW1-1:0]      fin1_ff [4];
   logic signed [SUMW-1:0]     acc [4];
   logic signed [SUMW-1:0]     v [4];
   logic signed [CW-1:0]       out_ff [4];
   logic                       lin_out_ff;
   logic [T_W-1:0]             t_raw;

   // The whole pipeline moves when the output register is free or taken.
   assign en         = !valid_ff[P_OUT] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[P_OUT];

   // Closeness threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 11'd1;
      end else if (csr_wen) begin
         thr_ff <= csr_wdata;
      end
   end

   // Valid bits travel with the items.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= P_OUT; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req_tvalid;
         for (int i = 1; i <= P_OUT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // Dot sign, distance from one and the cosine term.
   assign dot_ext = (DW+1)'(dot_ff);
   assign dabs    = (dot_ff < 0) ? -dot_ext : dot_ext;
   assign dot_gap = ONE_DOT - (DW+2)'(dabs);
   assign lin_in  = dot_gap <= $signed((DW+2)'(thr_ff));
   assign c_in    = C_W'(dabs[FRAC_BITS-1:0]) << (C_W - FRAC_BITS);

   assign t_raw = req_tdata[8*CW +: T_W];

   // Side values: unpacked at entry, updated where a stage settles them.
   always_comb begin
      side_in[0].t   = (t_raw > WEIGHT_ONE) ? WEIGHT_ONE : t_raw;
      side_in[0].lin = 1'b0;
      side_in[0].c   = '0;
      side_in[0].s   = '0;
      for (int k = 0; k < 4; k++) begin
         side_in[0].a[k] = req_tdata[k*CW +: CW];
         side_in[0].b[k] = (CW+1)'($signed(req_tdata[(4+k)*CW +: CW]));
      end
      for (int i = 1; i <= P_PRD; i++) begin
         side_in[i] = side_ff[i-1];
         if (i == P_SGN) begin
            side_in[i].lin = lin_in;
            side_in[i].c   = c_in;
            for (int k = 0; k < 4; k++) begin
               side_in[i].b[k] = (dot_ff < 0) ? -side_ff[i-1].b[k] : side_ff[i-1].b[k];
            end
         end
         // The root of an item appears while that item sits in stage P_ROOT.
         if (i == P_ROOT + 1) begin
            side_in[i].s = root;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= P_PRD; i++) side_ff[i] <= side_in[i];
      end
   end

   // Front stages: component products, dot product, radicand.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= $signed(side_ff[P_IN].a[k]) * $signed(CW'(side_ff[P_IN].b[k]));
         end
         dot_ff <= DW'(prod_ff[0] >>> FRAC_BITS) + DW'(prod_ff[1] >>> FRAC_BITS)
                 + DW'(prod_ff[2] >>> FRAC_BITS) + DW'(prod_ff[3] >>> FRAC_BITS);
         cc_ff  <= side_ff[P_SGN].c * side_ff[P_SGN].c;
         rad_ff <= RAD_ONE - RAD_W'(cc_ff);
      end
   end

   qslerp_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .rad_in   (rad_ff),
      .root_out (root)
   );

   qslerp_cordic_vec u_vec (
      .clock     (clock),
      .en        (en),
      .cos_in    (side_ff[P_ROOT].c),
      .sin_in    (root),
      .angle_out (angle)
   );

   // Arc split: a1 = t * w, a0 = w - a1.
   assign wpos = (angle < 0) ? '0 : T_W'(angle);

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff  <= wpos;
         tw_ff <= side_ff[P_ANG].t * wpos;
         a1_ff <= $signed(Z_W'(tw_ff >> 16));
         a0_ff <= $signed(Z_W'(w_ff)) - $signed(Z_W'(tw_ff >> 16));
      end
   end

   qslerp_cordic_rot u_rot1 (
      .clock    (clock),
      .en       (en),
      .angle_in (a1_ff),
      .sine_out (sine1)
   );

   qslerp_cordic_rot u_rot0 (
      .clock    (clock),
      .en       (en),
      .angle_in (a0_ff),
      .sine_out (sine0)
   );

   qslerp_div u_div1 (
      .clock    (clock),
      .en       (en),
      .sine_in  (sine1),
      .root_in  (side_ff[P_SIN].s),
      .quot_out (q1)
   );

   qslerp_div u_div0 (
      .clock    (clock),
      .en       (en),
      .sine_in  (sine0),
      .root_in  (side_ff[P_SIN].s),
      .quot_out (q0)
   );

   // Weight selection: linear (1-t, t) or the spherical quotients.
   assign s1_lin = ROOT_W'(side_ff[P_QUO].t) << 14;
   assign s1_sel = side_ff[P_QUO].lin ? s1_lin : q1;
   assign s0_sel = side_ff[P_QUO].lin ? (W_ONE - s1_lin) : q0;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            fin0_ff[k] <= $signed({1'b0, s0_sel}) * $signed(side_ff[P_QUO].a[k]);
            fin1_ff[k] <= $signed({1'b0, s1_sel}) * $signed(side_ff[P_QUO].b[k]);
         end
      end
   end

   // Round, scale and saturate each component.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         acc[k] = SUMW'(fin0_ff[k]) + SUMW'(fin1_ff[k]) + ROUND;
         v[k]   = acc[k] >>> 30;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            if (v[k] > MAXV) begin
               out_ff[k] <= CW'(MAXV);
            end else if (v[k] < MINV) begin
               out_ff[k] <= CW'(MINV);
            end else begin
               out_ff[k] <= CW'(v[k]);
            end
         end
         lin_out_ff <= side_ff[P_PRD].lin;
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < 4; k++) rsp_tdata[k*CW +: CW] = out_ff[k];
   end

   assign rsp_tuser = lin_out_ff;

endmodule

[hw/rtl/qslerp_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module qslerp_isqrt (
   input  logic                           clock,
   input  logic                           en,
   input  logic [qslerp_pkg::RAD_W-1:0]   rad_in,
   output logic [qslerp_pkg::ROOT_W-1:0]  root_out
);
   import qslerp_pkg::*;

   logic [RAD_W-1:0] n_ff   [ISQ_STAGES];
   logic [REM_W-1:0] res_ff [ISQ_STAGES];

   genvar j;
   generate
      for (j = 0; j < ISQ_STAGES; j++) begin : g_stage
         logic [RAD_W-1:0] n_pv;
         logic [REM_W-1:0] res_pv;
         logic [REM_W-1:0] trial;
         logic [REM_W-1:0] bit_v;
         logic             take;
         logic [RAD_W-1:0] n_in;
         logic [REM_W-1:0] res_in;

         if (j == 0) begin : g_first
            assign n_pv   = rad_in;
            assign res_pv = '0;
         end else begin : g_next
            assign n_pv   = n_ff[j-1];
            assign res_pv = res_ff[j-1];
         end

         // Try the next square bit against what is left of the radicand.
         // The partial result is shifted down each stage and equals the root after the last stage.
         assign bit_v  = REM_W'(1) << (2 * (ISQ_STAGES - 1 - j));
         assign trial  = res_pv + bit_v;
         assign take   = REM_W'(n_pv) >= trial;
         assign n_in   = take ? RAD_W'(REM_W'(n_pv) - trial) : n_pv;
         assign res_in = take ? ((res_pv >> 1) + bit_v) : (res_pv >> 1);

         always_ff @(posedge clock) begin
            if (en) begin
               n_ff[j]   <= n_in;
               res_ff[j] <= res_in;
            end
         end
      end
   endgenerate

   assign root_out = res_ff[ISQ_STAGES-1][ROOT_W-1:0];

endmodule

[hw/rtl/qslerp_cordic_vec.sv]
// Pipelined CORDIC in vectoring mode: angle of the vector (cos, sin).
`timescale 1ns / 1ps

module qslerp_cordic_vec (
   input  logic                                clock,
   input  logic                                en,
   input  logic [qslerp_pkg::C_W-1:0]          cos_in,
   input  logic [qslerp_pkg::ROOT_W-1:0]       sin_in,
   output logic signed [qslerp_pkg::Z_W-1:0]   angle_out
);
   import qslerp_pkg::*;

   logic signed [CX_W-1:0] x_ff [CORDIC_STEPS];
   logic signed [CX_W-1:0] y_ff [CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_ff [CORDIC_STEPS];

   genvar i;
   generate
      for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
         logic signed [CX_W-1:0] x_pv, y_pv, x_in, y_in;
         logic signed [Z_W-1:0]  z_pv, z_in, da;

         if (i == 0) begin : g_first
            assign x_pv = $signed(CX_W'(cos_in));
            assign y_pv = $signed(CX_W'(sin_in));
            assign z_pv = '0;
         end else begin : g_next
            assign x_pv = x_ff[i-1];
            assign y_pv = y_ff[i-1];
            assign z_pv = z_ff[i-1];
         end

         // Rotate towards the x axis and accumulate the angle turned.
         assign da   = $signed(Z_W'(atan_q16(5'(i))));
         assign x_in = (y_pv >= 0) ? x_pv + (y_pv >>> i) : x_pv - (y_pv >>> i);
         assign y_in = (y_pv >= 0) ? y_pv - (x_pv >>> i) : y_pv + (x_pv >>> i);
         assign z_in = (y_pv >= 0) ? z_pv + da : z_pv - da;

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[i] <= x_in;
               y_ff[i] <= y_in;
               z_ff[i] <= z_in;
            end
         end
      end
   endgenerate

   assign angle_out = z_ff[CORDIC_STEPS-1];

endmodule

[hw/rtl/qslerp_cordic_rot.sv]
// Pipelined CORDIC in rotation mode: sine of an angle, Q2.30.
`timescale 1ns / 1ps

module qslerp_cordic_rot (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [qslerp_pkg::Z_W-1:0]   angle_in,
   output logic signed [qslerp_pkg::CX_W-1:0]  sine_out
);
   import qslerp_pkg::*;

   logic signed [CX_W-1:0] x_ff [CORDIC_STEPS];
   logic signed [CX_W-1:0] y_ff [CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_ff [CORDIC_STEPS];

   genvar i;
   generate
      for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
         logic signed [CX_W-1:0] x_pv, y_pv, x_in, y_in;
         logic signed [Z_W-1:0]  z_pv, z_in, da;

         if (i == 0) begin : g_first
            assign x_pv = $signed(CX_W'(GAIN_INV));
            assign y_pv = '0;
            assign z_pv = angle_in;
         end else begin : g_next
            assign x_pv = x_ff[i-1];
            assign y_pv = y_ff[i-1];
            assign z_pv = z_ff[i-1];
         end

         // Turn the unit vector until the residual angle reaches zero.
         assign da   = $signed(Z_W'(atan_q16(5'(i))));
         assign x_in = (z_pv >= 0) ? x_pv - (y_pv >>> i) : x_pv + (y_pv >>> i);
         assign y_in = (z_pv >= 0) ? y_pv + (x_pv >>> i) : y_pv - (x_pv >>> i);
         assign z_in = (z_pv >= 0) ? z_pv - da : z_pv + da;

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[i] <= x_in;
               y_ff[i] <= y_in;
               z_ff[i] <= z_in;
            end
         end
      end
   endgenerate

   assign sine_out = y_ff[CORDIC_STEPS-1];

endmodule

[hw/rtl/qslerp_div.sv]
// Pipelined restoring divider: sine * 2^30 / root, held to one.
`timescale 1ns / 1ps

module qslerp_div (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [qslerp_pkg::CX_W-1:0]  sine_in,
   input  logic [qslerp_pkg::ROOT_W-1:0]       root_in,
   output logic [qslerp_pkg::ROOT_W-1:0]       quot_out
);
   import qslerp_pkg::*;

   localparam int QB = DIV_STAGES - 1;
   localparam logic [ROOT_W-1:0] Q_ONE = ROOT_W'(1) << 30;

   logic [REM_W-1:0]  rem_ff [DIV_STAGES];
   logic [ROOT_W-1:0] den_ff [DIV_STAGES];
   logic [ROOT_W-1:0] q_ff   [DIV_STAGES];
   logic              sat_ff [DIV_STAGES];

   logic [31:0] sn_pos;

   // A negative sine counts as zero; a quotient of two or more saturates.
   assign sn_pos = (sine_in < 0) ? '0 : sine_in[31:0];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= REM_W'(sn_pos) << 30;
         den_ff[0] <= root_in;
         q_ff[0]   <= '0;
         sat_ff[0] <= 33'(sn_pos) >= (33'(root_in) << 1);
      end
   end

   genvar j;
   generate
      for (j = 1; j < DIV_STAGES; j++) begin : g_stage
         logic [REM_W-1:0]  d;
         logic              take;
         logic [ROOT_W-1:0] q_new;

         // One quotient bit, most significant first.
         assign d     = REM_W'(den_ff[j-1]) << (QB - j);
         assign take  = rem_ff[j-1] >= d;
         assign q_new = q_ff[j-1] | (take ? (ROOT_W'(1) << (QB - j)) : '0);

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= take ? rem_ff[j-1] - d : rem_ff[j-1];
               den_ff[j] <= den_ff[j-1];
               sat_ff[j] <= sat_ff[j-1];
               if (j == QB) begin
                  q_ff[j] <= (sat_ff[j-1] || q_new > Q_ONE) ? Q_ONE : q_new;
               end else begin
                  q_ff[j] <= q_new;
               end
            end
         end
      end
   endgenerate

   assign quot_out = q_ff[QB];

endmodule

[verif/quaternion_slerp_test.sv]
// Self-checking testbench of the fixed-point quaternion slerp pipeline.
`timescale 1ns / 1ps

module quaternion_slerp_test;
   import qslerp_pkg::*;

   localparam int REQ_W     = 152;
   localparam int RSP_W     = 64;
   localparam int IDLE_MAX  = 5000;
   localparam int DRAIN     = 130;
   localparam int RAND_ITEMS = 2000;

   typedef logic signed [15:0] comp_type;

   typedef struct {
      comp_type q[4];
      bit       lin;
   } blend_type;

   // Predicts the blended quaternion of each accepted item and holds it until the result comes.
   class blend_board;
      blend_type awaited[$];
      int      errors;
      longint  threshold;
      longint  arc_table[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                                  128, 64, 32, 16, 8, 4, 2, 1};

      function new();
         errors    = 0;
         threshold = 1;
      endfunction

      function longint unsigned root(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // Vectoring rotation: angle of (x, y) in Q16 radians.
      function longint arc_of(longint x, longint y);
         longint z, dx, dy;
         z = 0;
         for (int i = 0; i < 17; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += arc_table[i];
            end else begin
               x -= dx; y += dy; z -= arc_table[i];
            end
         end
         return z;
      endfunction

      // Rotation from the gain-corrected unit vector; the y result is the sine in Q2.30.
      function longint sine_of(longint z);
         longint x, y, dx, dy;
         x = 652032874;
         y = 0;
         for (int i = 0; i < 17; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= arc_table[i];
            end else begin
               x += dx; y -= dy; z += arc_table[i];
            end
         end
         return y;
      endfunction

      function longint arc_weight(longint ang, longint unsigned s);
         longint sn;
         longint unsigned q;
         sn = sine_of(ang);
         if (sn < 0) sn = 0;
         q = (longint'(sn) << 30) / s;
         if (q > (64'd1 << 30)) q = 64'd1 << 30;
         return longint'(q);
      endfunction

      function void note(logic [REQ_W-1:0] d);
         longint a[4], b[4], dot, s0, s1, v, w, a1, t;
         longint unsigned c, s;
         blend_type e;
         dot = 0;
         t = d[144:128];
         if (t > 65536) t = 65536;
         for (int k = 0; k < 4; k++) begin
            a[k] = comp_type'(d[16*k +: 16]);
            b[k] = comp_type'(d[64 + 16*k +: 16]);
            dot += (a[k] * b[k]) >>> 14;
         end
         // Negative dot: take the shorter arc by flipping the target.
         if (dot < 0) begin
            dot = -dot;
            for (int k = 0; k < 4; k++) b[k] = -b[k];
         end
         e.lin = ((16384 - dot) <= threshold);
         if (e.lin) begin
            s1 = t << 14;
            s0 = (64'sd1 << 30) - s1;
         end else begin
            c = longint'(dot) << 16;
            s = root((64'd1 << 60) - c * c);
            if (s == 0) s = 1;
            w = arc_of(longint'(c), longint'(s));
            if (w < 0) w = 0;
            a1 = (t * w) >>> 16;
            s1 = arc_weight(a1, s);
            s0 = arc_weight(w - a1, s);
         end
         for (int k = 0; k < 4; k++) begin
            v = (s0 * a[k] + s1 * b[k] + (64'sd1 << 29)) >>> 30;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            e.q[k] = comp_type'(v);
         end
         awaited.push_back(e);
      endfunction

      function void check(logic [RSP_W-1:0] d, logic lin);
         blend_type e;
         if (awaited.size() == 0) begin
            $display("%0t: result with nothing awaited: data %h linear %b", $time, d, lin);
            errors++;
            return;
         end
         e = awaited.pop_front();
         for (int k = 0; k < 4; k++)
            if (comp_type'(d[16*k +: 16]) !== e.q[k]) begin
               $display("%0t: component %0d expected %0d actual %0d", $time, k, e.q[k],
                        comp_type'(d[16*k +: 16]));
               errors++;
            end
         if (lin !== e.lin) begin
            $display("%0t: linear_case expected %b actual %b", $time, e.lin, lin);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic [REQ_W-1:0]   req_tdata;
   logic               req_tvalid;
   logic               req_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               rsp_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic               csr_wen;
   logic [10:0]        csr_wdata;

   blend_board board = new();
   bit          calm = 0;
   int          quiet = 0;

   quaternion_slerp i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Note accepted items, check results and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
            quiet <= 0;
         end else if (quiet >= IDLE_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
      end
   end

   // Receiver stalls in bursts until the calm phase.
   initial begin
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         rsp_tready <= 1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if (!calm) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   task automatic send_item(input comp_type f[4], input comp_type g[4], input logic [16:0] wt);
      logic [REQ_W-1:0] d;
      d = '0;
      for (int k = 0; k < 4; k++) begin
         d[16*k +: 16]      = f[k];
         d[64 + 16*k +: 16] = g[k];
      end
      d[144:128] = wt;
      req_tdata  <= d;
      req_tvalid <= 1;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic write_threshold(input logic [10:0] v);
      req_tvalid <= 0;
      do @(posedge clock); while (board.awaited.size() != 0);
      repeat (4) @(posedge clock);
      csr_wen   <= 1;
      csr_wdata <= v;
      board.threshold = v;
      @(posedge clock);
      csr_wen <= 0;
   endtask

   function automatic comp_type pick_raw();
      return comp_type'($urandom_range(0, 65535));
   endfunction

   // Random direction scaled to unit length in Q1.14.
   function automatic void unit_quat(output comp_type q[4]);
      real v[4], n;
      n = 0.0;
      for (int k = 0; k < 4; k++) begin
         v[k] = real'(int'($urandom_range(0, 65535)) - 32768);
         n += v[k] * v[k];
      end
      if (n == 0.0) begin
         v[3] = 1.0;
         n = 1.0;
      end
      n = $sqrt(n);
      for (int k = 0; k < 4; k++) q[k] = comp_type'($rtoi(v[k] / n * 16384.0));
   endfunction

   function automatic logic [16:0] pick_weight();
      case ($urandom_range(0, 9))
         0:       return 17'($urandom_range(0, 131071));
         1:       return 17'd65536;
         2:       return 17'd0;
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic random_items(input int n);
      comp_type f[4], g[4];
      int    sel, d;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         unit_quat(f);
         if (sel < 40) begin
            unit_quat(g);
         end else if (sel < 85) begin
            // Nearby target, sometimes on the far hemisphere.
            d = $urandom_range(0, 60);
            for (int k = 0; k < 4; k++) begin
               g[k] = f[k] + comp_type'(int'($urandom_range(0, 2 * d)) - d);
               if (sel >= 70) g[k] = -g[k];
            end
         end else begin
            for (int k = 0; k < 4; k++) begin
               f[k] = pick_raw();
               g[k] = pick_raw();
            end
         end
         send_item(f, g, pick_weight());
      end
   endtask

   initial begin
      comp_type f[4], g[4];
      logic [10:0] settings[5];
      settings   = '{11'd0, 11'd1024, 11'd2047, 11'd16, 11'd1};
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = '0;
      csr_wen    = 0;
      csr_wdata  = '0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, zero and negative dot, identical inputs, weight limits.
      f = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
      send_item(f, f, 17'd65536);
      g = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
      send_item(g, g, 17'd131071);
      send_item(f, g, 17'd32768);
      f = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
      g = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      send_item(f, g, 17'd0);
      send_item(f, g, 17'd32768);
      send_item(f, g, 17'd65536);
      g = '{16'sd0, 16'sd0, 16'sd0, -16'sd16384};
      send_item(f, g, 17'd16384);
      send_item(f, f, 17'd40000);
      g = '{16'sd0, 16'sd11585, 16'sd0, 16'sd11585};
      send_item(f, g, 17'd65537);
      g = '{16'sd0, -16'sd11585, 16'sd0, -16'sd11585};
      send_item(f, g, 17'd20000);
      g = '{16'sd100, 16'sd0, 16'sd0, 16'sd16383};
      send_item(f, g, 17'd50000);
      g = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
      send_item(f, g, 17'd10000);

      // Random phases across the threshold settings, the last one without idling.
      foreach (settings[p]) begin
         write_threshold(settings[p]);
         if (p == 4) calm = 1;
         random_items(RAND_ITEMS / 5);
      end
      write_threshold(11'($urandom_range(0, 2047)));
      random_items(20);

      req_tvalid <= 0;
      do @(posedge clock); while (board.awaited.size() != 0);
      repeat (DRAIN) @(posedge clock);
      if (board.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
